// ===== design/ckx_pkg.sv =====
// ============================================================================
// ckx_pkg: shared types, codes and lookup functions
// Character codes, alphabet modes, register indexes and symbol lookup for
// the canonical k-mer extractor.
// ============================================================================
`default_nettype none

package ckx_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int SYM_W      = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVCOMP_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PURPYR_MAP  = 3'd4;

    // Alphabet modes
    localparam logic [1:0] ALPHA_NT = 2'd0;
    localparam logic [1:0] ALPHA_RY = 2'd1;
    localparam logic [1:0] ALPHA_AA = 2'd2;

    // Reset values of the registers
    localparam logic [5:0] RST_KMER_LENGTH = 6'd10;

    // Characters
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_Y  = 8'h59;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Packed group size on the output
    localparam int GROUP_W = 7;

    // Decoded input byte
    typedef struct packed {
        logic             is_gt;
        logic             is_nl;
        logic             hit;
        logic [SYM_W-1:0] code;
    } t_dec;

    // Per-feature settings carried down the emit pipeline
    typedef struct packed {
        logic [1:0] mode;
        logic       rc_en;
    } t_feat_cfg;

    // Code mask of an alphabet mode
    function automatic logic [SYM_W-1:0] code_mask(input logic [1:0] mode);
        logic [SYM_W-1:0] m;
        case (mode)
            ALPHA_NT: m = 5'h03;
            ALPHA_RY: m = 5'h01;
            default:  m = 5'h1F;
        endcase
        return m;
    endfunction

    // Amino acid lookup in sorted order; bit 5 is the hit flag
    function automatic logic [SYM_W:0] amino_code(input logic [7:0] c);
        logic [SYM_W:0] r;
        case (c)
            8'h41:   r = {1'b1, 5'd0};   // A
            8'h43:   r = {1'b1, 5'd1};   // C
            8'h44:   r = {1'b1, 5'd2};   // D
            8'h45:   r = {1'b1, 5'd3};   // E
            8'h46:   r = {1'b1, 5'd4};   // F
            8'h47:   r = {1'b1, 5'd5};   // G
            8'h48:   r = {1'b1, 5'd6};   // H
            8'h49:   r = {1'b1, 5'd7};   // I
            8'h4B:   r = {1'b1, 5'd8};   // K
            8'h4C:   r = {1'b1, 5'd9};   // L
            8'h4D:   r = {1'b1, 5'd10};  // M
            8'h4E:   r = {1'b1, 5'd11};  // N
            8'h50:   r = {1'b1, 5'd12};  // P
            8'h51:   r = {1'b1, 5'd13};  // Q
            8'h52:   r = {1'b1, 5'd14};  // R
            8'h53:   r = {1'b1, 5'd15};  // S
            8'h54:   r = {1'b1, 5'd16};  // T
            8'h56:   r = {1'b1, 5'd17};  // V
            8'h57:   r = {1'b1, 5'd18};  // W
            8'h59:   r = {1'b1, 5'd19};  // Y
            default: r = {1'b0, 5'd0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ckx_if.sv =====
// ============================================================================
// ckx_if: channel interfaces
// Text input stream, packed output stream and register write channel.
// ============================================================================
`default_nettype none

interface ckx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ckx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_byte;

    modport source (output valid, output packed_byte, output last_byte, input ready);
    modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

interface ckx_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ckx_pkg::CFG_IDX_W-1:0]  index;
    logic [ckx_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ckx_decode.sv =====
// ============================================================================
// ckx_decode: input byte classifier
// Fold case, apply the purine/pyrimidine map and look the byte up in the
// selected alphabet.
// ============================================================================
`default_nettype none

module ckx_decode (
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_fold,
    input  wire logic        i_pp_map,
    input  wire logic [1:0]  i_mode,
    output ckx_pkg::t_dec    o_dec
);

    logic [7:0]                  w_fold;
    logic [7:0]                  w_map;
    logic [ckx_pkg::SYM_W:0]     w_aa;

    always_comb begin
        w_fold = i_byte;
        if (i_fold && i_byte >= ckx_pkg::CH_LA && i_byte <= ckx_pkg::CH_LZ) begin
            w_fold = i_byte - ckx_pkg::CASE_OFS;
        end

        w_map = w_fold;
        if (i_pp_map) begin
            if (w_fold == ckx_pkg::CH_A || w_fold == ckx_pkg::CH_G) begin
                w_map = ckx_pkg::CH_R;
            end else if (w_fold == ckx_pkg::CH_C || w_fold == ckx_pkg::CH_T) begin
                w_map = ckx_pkg::CH_Y;
            end
        end

        w_aa = ckx_pkg::amino_code(w_map);

        o_dec.is_gt = (i_byte == ckx_pkg::CH_GT);
        o_dec.is_nl = (i_byte == ckx_pkg::CH_NL);
        o_dec.hit   = 1'b0;
        o_dec.code  = '0;
        case (i_mode)
            ckx_pkg::ALPHA_NT: begin
                o_dec.hit = 1'b1;
                if (w_map == ckx_pkg::CH_A) begin
                    o_dec.code = 5'd0;
                end else if (w_map == ckx_pkg::CH_C) begin
                    o_dec.code = 5'd1;
                end else if (w_map == ckx_pkg::CH_G) begin
                    o_dec.code = 5'd2;
                end else if (w_map == ckx_pkg::CH_T) begin
                    o_dec.code = 5'd3;
                end else begin
                    o_dec.hit = 1'b0;
                end
            end
            ckx_pkg::ALPHA_RY: begin
                o_dec.hit  = (w_map == ckx_pkg::CH_R) || (w_map == ckx_pkg::CH_Y);
                o_dec.code = {4'd0, (w_map == ckx_pkg::CH_Y)};
            end
            ckx_pkg::ALPHA_AA: begin
                o_dec.hit  = w_aa[ckx_pkg::SYM_W];
                o_dec.code = w_aa[ckx_pkg::SYM_W-1:0];
            end
            default: begin
                // unused mode takes no symbol
                o_dec.hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ckx_cell.sv =====
// ============================================================================
// ckx_cell: one window cell
// Holds one symbol code, takes its neighbor's code on every append and
// presents the code masked to the current alphabet.
// ============================================================================
`default_nettype none

module ckx_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_shift,
    input  wire logic [ckx_pkg::SYM_W-1:0] i_sym,
    input  wire logic [ckx_pkg::SYM_W-1:0] i_mask,
    output logic      [ckx_pkg::SYM_W-1:0] o_sym,
    output logic      [ckx_pkg::SYM_W-1:0] o_code
);

    logic [ckx_pkg::SYM_W-1:0] r_sym;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sym <= i_sym;
        end
    end

    assign o_sym  = r_sym;
    assign o_code = r_sym & i_mask;

endmodule

`default_nettype wire

// ===== design/ckx_align.sv =====
// ============================================================================
// ckx_align: feature alignment stage
// Hold a window snapshot, shift its newest k symbols to the front, build the
// reverse complement (ACGT, RY modes) and pack both MSB-first at the code width.
// ============================================================================
`default_nettype none

module ckx_align #(
    parameter int MAX_K = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // snapshot side
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [5*MAX_K-1:0]          i_win,
    input  wire logic [$clog2(MAX_K+1)-1:0]  i_k,
    input  wire ckx_pkg::t_feat_cfg          i_cfg,
    // packed side
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [5*MAX_K-1:0]               o_fw,
    output logic [2*MAX_K-1:0]               o_rc,
    output logic [$clog2(5*MAX_K+1)-1:0]     o_nbits,
    output logic                             o_use_rc
);

    localparam int KW   = $clog2(MAX_K+1);
    localparam int NBW  = $clog2(5*MAX_K+1);
    localparam int FW_W = 5*MAX_K;
    localparam int RC_W = 2*MAX_K;

    // stage 1: snapshot
    logic                          r_s1_valid;
    logic [ckx_pkg::SYM_W-1:0]     r_win [0:MAX_K-1];
    logic [KW-1:0]                 r_k;
    ckx_pkg::t_feat_cfg            r_cfg;

    // stage 2: packed feature
    logic                          r_s2_valid;
    logic [FW_W-1:0]               r_fw;
    logic [RC_W-1:0]               r_rc;
    logic [NBW-1:0]                r_nbits;
    logic                          r_use_rc;

    logic                          w_s2_free;
    logic                          w_s1_take;
    logic [KW-1:0]                 w_sh;
    logic [ckx_pkg::SYM_W-1:0]     w_stg [0:KW][0:MAX_K-1];
    logic [ckx_pkg::SYM_W-1:0]     w_mask;
    logic [FW_W-1:0]               n_fw;
    logic [RC_W-1:0]               n_rc;
    logic [NBW-1:0]                n_nbits;

    assign w_s2_free = !r_s2_valid || i_ready;
    assign w_s1_take = r_s1_valid && w_s2_free;
    assign o_ready   = !r_s1_valid || w_s1_take;

    assign w_sh   = KW'(MAX_K) - r_k;
    assign w_mask = ckx_pkg::code_mask(r_cfg.mode);

    // Log shifter: oldest-first order, drop the MAX_K-k symbols ahead of the feature
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_stg[0][i] = r_win[MAX_K-1-i];
        end
        for (int s = 0; s < KW; s++) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (!w_sh[s]) begin
                    w_stg[s+1][i] = w_stg[s][i];
                end else if (i + (1 << s) < MAX_K) begin
                    w_stg[s+1][i] = w_stg[s][i + (1 << s)];
                end else begin
                    w_stg[s+1][i] = '0;
                end
            end
        end
    end

    // Pack forward and reverse complement at the code width
    always_comb begin
        n_fw = '0;
        n_rc = '0;
        for (int i = 0; i < MAX_K; i++) begin
            case (r_cfg.mode)
                ckx_pkg::ALPHA_NT: begin
                    n_fw[FW_W-1-2*i -: 2] = w_stg[KW][i][1:0];
                    if (r_k > KW'(i)) begin
                        n_rc[RC_W-1-2*i -: 2] = ~r_win[i][1:0];
                    end
                end
                ckx_pkg::ALPHA_RY: begin
                    n_fw[FW_W-1-i] = w_stg[KW][i][0];
                    if (r_k > KW'(i)) begin
                        n_rc[RC_W-1-i] = ~r_win[i][0];
                    end
                end
                default: begin
                    n_fw[FW_W-1-5*i -: 5] = w_stg[KW][i] & w_mask;
                end
            endcase
        end

        case (r_cfg.mode)
            ckx_pkg::ALPHA_NT: n_nbits = NBW'(r_k) << 1;
            ckx_pkg::ALPHA_RY: n_nbits = NBW'(r_k);
            default:           n_nbits = (NBW'(r_k) << 2) + NBW'(r_k);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int i = 0; i < MAX_K; i++) begin
                r_win[i] <= i_win[5*i +: 5];
            end
            r_k   <= i_k;
            r_cfg <= i_cfg;
        end
        if (w_s1_take) begin
            r_fw     <= n_fw;
            r_rc     <= n_rc;
            r_nbits  <= n_nbits;
            r_use_rc <= r_cfg.rc_en &&
                        (r_cfg.mode == ckx_pkg::ALPHA_NT || r_cfg.mode == ckx_pkg::ALPHA_RY);
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_fw     = r_fw;
    assign o_rc     = r_rc;
    assign o_nbits  = r_nbits;
    assign o_use_rc = r_use_rc;

endmodule

`default_nettype wire

// ===== design/ckx_serializer.sv =====
// ============================================================================
// ckx_serializer: canonical pick and byte serializer
// Choose the smaller strand, then send the packed bits seven at a time with
// the spacer bit set and the final byte of each feature marked.
// ============================================================================
`default_nettype none

module ckx_serializer #(
    parameter int MAX_K = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [5*MAX_K-1:0]           i_fw,
    input  wire logic [2*MAX_K-1:0]           i_rc,
    input  wire logic [$clog2(5*MAX_K+1)-1:0] i_nbits,
    input  wire logic                         i_use_rc,
    ckx_out_if.source                         o_feat
);

    localparam int NBW   = $clog2(5*MAX_K+1);
    localparam int FW_W  = 5*MAX_K;
    localparam int RC_W  = 2*MAX_K;
    localparam int GW    = ckx_pkg::GROUP_W;
    localparam int SER_W = GW*((FW_W + GW - 1)/GW);

    logic              r_busy;
    logic [SER_W-1:0]  r_sh;
    logic [NBW-1:0]    r_left;

    logic              w_pop;
    logic              w_last;
    logic              w_load;
    logic [FW_W-1:0]   w_pick;

    assign w_last  = (r_left <= NBW'(GW));
    assign w_pop   = r_busy && o_feat.ready;
    assign o_ready = !r_busy || (w_pop && w_last);
    assign w_load  = i_valid && o_ready;

    // Fixed-width codes: numeric order equals symbol-by-symbol order
    assign w_pick = (i_use_rc && (i_rc < i_fw[FW_W-1 -: RC_W]))
                  ? (FW_W'(i_rc) << (FW_W - RC_W)) : i_fw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_pop && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sh   <= SER_W'(w_pick) << (SER_W - FW_W);
            r_left <= i_nbits;
        end else if (w_pop) begin
            r_sh   <= r_sh << GW;
            r_left <= r_left - NBW'(GW);
        end
    end

    assign o_feat.valid       = r_busy;
    assign o_feat.packed_byte = {1'b1, r_sh[SER_W-1 -: GW]};
    assign o_feat.last_byte   = w_last;

endmodule

`default_nettype wire

// ===== design/canonical_kmer_extractor_top.sv =====
// ============================================================================
// canonical_kmer_extractor_top: canonical k-mer extractor
// FASTA text in, packed canonical k-mer features out, seven bits per byte.
// ============================================================================
// Usage:
//   i_text  : one FASTA character per transfer. Headers ('>' to newline) and
//             newlines take no symbol; an unknown letter clears the window.
//   o_feat  : one packed byte per transfer, bit 7 always set, last_byte high
//             on the final byte of a feature. A feature of k symbols at b
//             bits per code takes ceil(b*k/7) transfers, sent back to back.
//   i_cfg   : register writes (index, data), always ready. Write only while
//             the block holds no work in flight.
// Throughput: one text byte per cycle while the emit pipeline has room. The
//   byte serializer sends one byte per cycle while o_feat is ready, so under
//   a steady stream of features it sets the rate at which text is accepted;
//   two feature slots ahead of it absorb short bursts.
// Path: a byte that completes a window reaches the output through the
//   snapshot, align/pack and serializer registers, in that order.
// Reset: window empty, header flag low, registers at their defaults
//   (k=10, nucleotides, reverse complement on, no folding, no RY map).
// Stall: with o_feat held off, the serializer holds its byte, the align
//   stages fill, and i_text.ready drops until the snapshot slot frees.
// ============================================================================
`default_nettype none

module canonical_kmer_extractor_top #(
    parameter int MAX_K = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ckx_in_if.sink     i_text,
    ckx_out_if.source  o_feat,
    ckx_cfg_if.sink    i_cfg
);

    localparam int KW  = $clog2(MAX_K+1);
    localparam int NBW = $clog2(5*MAX_K+1);
    localparam int SW  = ckx_pkg::SYM_W;

    // configuration registers
    logic [5:0]  r_kmer_length;
    logic [1:0]  r_alpha_mode;
    logic        r_revcomp_en;
    logic        r_fold_lower;
    logic        r_pp_map;

    // window control
    logic          r_in_header;
    logic [KW-1:0] r_fill;
    logic [KW-1:0] n_fill;

    ckx_pkg::t_dec      w_dec;
    ckx_pkg::t_feat_cfg w_feat_cfg;
    logic               w_acc;
    logic               w_append;
    logic               w_emit;
    logic [KW-1:0]      w_k;
    logic [KW-1:0]      w_fill_app;
    logic [SW-1:0]      w_mask;
    logic [SW-1:0]      w_chain [0:MAX_K];
    logic [SW-1:0]      w_code  [0:MAX_K-1];
    logic [5*MAX_K-1:0] w_snap;

    // align -> serializer
    logic               w_al_ready;
    logic               w_pk_valid;
    logic               w_pk_ready;
    logic [5*MAX_K-1:0] w_pk_fw;
    logic [2*MAX_K-1:0] w_pk_rc;
    logic [NBW-1:0]     w_pk_nbits;
    logic               w_pk_use_rc;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= ckx_pkg::RST_KMER_LENGTH;
            r_alpha_mode  <= ckx_pkg::ALPHA_NT;
            r_revcomp_en  <= 1'b1;
            r_fold_lower  <= 1'b0;
            r_pp_map      <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ckx_pkg::REG_KMER_LENGTH: r_kmer_length <= i_cfg.data;
                ckx_pkg::REG_ALPHA_MODE:  r_alpha_mode  <= i_cfg.data[1:0];
                ckx_pkg::REG_REVCOMP_EN:  r_revcomp_en  <= i_cfg.data[0];
                ckx_pkg::REG_FOLD_LOWER:  r_fold_lower  <= i_cfg.data[0];
                ckx_pkg::REG_PURPYR_MAP:  r_pp_map      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Clamp k: zero acts as one, anything above the window depth saturates
    always_comb begin
        if (r_kmer_length == 6'd0) begin
            w_k = KW'(1);
        end else if ({2'b00, r_kmer_length} > 8'(MAX_K)) begin
            w_k = KW'(MAX_K);
        end else begin
            w_k = KW'(r_kmer_length);
        end
    end

    // ---------------------------------------------------------------- decode
    ckx_decode u_decode (
        .i_byte   (i_text.text_byte),
        .i_fold   (r_fold_lower),
        .i_pp_map (r_pp_map),
        .i_mode   (r_alpha_mode),
        .o_dec    (w_dec)
    );

    assign i_text.ready = w_al_ready;
    assign w_acc        = i_text.valid && i_text.ready;
    assign w_append     = w_acc && !w_dec.is_gt && !r_in_header && !w_dec.is_nl && w_dec.hit;

    // A full window drops its oldest symbol before the append
    assign w_fill_app = (r_fill >= KW'(MAX_K)) ? KW'(MAX_K) : r_fill + 1'b1;
    assign w_emit     = (w_fill_app >= w_k);

    always_comb begin
        n_fill = r_fill;
        if (w_acc) begin
            if (w_dec.is_gt) begin
                n_fill = '0;
            end else if (!r_in_header && !w_dec.is_nl) begin
                if (!w_dec.hit) begin
                    n_fill = '0;
                end else if (w_emit) begin
                    // keep the newest k-1 symbols
                    n_fill = w_k - 1'b1;
                end else begin
                    n_fill = w_fill_app;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_fill <= n_fill;
            if (w_acc) begin
                if (w_dec.is_gt) begin
                    r_in_header <= 1'b1;
                end else if (r_in_header && w_dec.is_nl) begin
                    r_in_header <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- window
    // Cell g holds the g-th newest symbol; every append moves the row by one.
    assign w_mask     = ckx_pkg::code_mask(r_alpha_mode);
    assign w_chain[0] = w_dec.code;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        ckx_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_append),
            .i_sym  (w_chain[g]),
            .i_mask (w_mask),
            .o_sym  (w_chain[g+1]),
            .o_code (w_code[g])
        );
    end

    // Snapshot of the row as it stands after this append
    always_comb begin
        w_snap[SW-1:0] = w_dec.code & w_mask;
        for (int i = 1; i < MAX_K; i++) begin
            w_snap[SW*i +: SW] = w_code[i-1];
        end
    end

    assign w_feat_cfg.mode  = r_alpha_mode;
    assign w_feat_cfg.rc_en = r_revcomp_en;

    // ---------------------------------------------------------------- emit
    ckx_align #(
        .MAX_K(MAX_K)
    ) u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_append && w_emit),
        .o_ready (w_al_ready),
        .i_win   (w_snap),
        .i_k     (w_k),
        .i_cfg   (w_feat_cfg),
        .o_valid (w_pk_valid),
        .i_ready (w_pk_ready),
        .o_fw    (w_pk_fw),
        .o_rc    (w_pk_rc),
        .o_nbits (w_pk_nbits),
        .o_use_rc(w_pk_use_rc)
    );

    ckx_serializer #(
        .MAX_K(MAX_K)
    ) u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pk_valid),
        .o_ready (w_pk_ready),
        .i_fw    (w_pk_fw),
        .i_rc    (w_pk_rc),
        .i_nbits (w_pk_nbits),
        .i_use_rc(w_pk_use_rc),
        .o_feat  (o_feat)
    );

    // ---------------------------------------------------------------- checks
    // After an emitting append the window keeps exactly k-1 symbols.
    a_fill_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_append && w_emit) |=> (r_fill == $past(w_k) - 1'b1))
        else $error("window fill wrong after feature emit");

    // A header start empties the window and enters the header.
    a_header_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_dec.is_gt) |=> (r_in_header && r_fill == '0))
        else $error("header start did not clear the window");

    // The bytes of one feature go out without a gap.
    a_feature_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_feat.valid && o_feat.ready && !o_feat.last_byte) |=> o_feat.valid)
        else $error("gap inside a packed feature");

    // The window never records more symbols than it can hold.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_append |=> (r_fill <= KW'(MAX_K)))
        else $error("window fill beyond depth");

endmodule

`default_nettype wire

// ===== tb/ckx_feature_checker.sv =====
// ============================================================================
// ckx_feature_checker: feature predictor and output checker
// Watches the text, packed output and register channels. Each text transfer
// is run through a bit-exact predictor of the k-mer extractor, and every
// output transfer is compared with the oldest owed byte.
// ============================================================================
module ckx_feature_checker #(
    parameter int MAX_K = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ckx_in_if    i_text,
    ckx_out_if   i_feat,
    ckx_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_bytes_owed,
    output int   o_feature_count
);

    localparam int SYM_W = ckx_pkg::SYM_W;
    localparam int GRP_W = ckx_pkg::GROUP_W;
    localparam logic [8*20-1:0] AMINO_ORDER = "ACDEFGHIKLMNPQRSTVWY";

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } t_feat_byte;

    t_feat_byte       owed_bytes[$];
    t_feat_byte       want;
    logic [SYM_W-1:0] window_syms [MAX_K];
    int               window_len;
    logic             header_open;
    logic [5:0]       kmer_len;
    logic [1:0]       alpha_mode;
    logic             rc_en;
    logic             fold_en;
    logic             map_en;
    int               mismatches = 0;
    int               features_seen = 0;

    // Symbol code of an upper-case letter in the given alphabet, -1 on a miss
    function automatic int symbol_code(input logic [7:0] c, input logic [1:0] mode);
        int code;
        code = -1;
        case (mode)
            ckx_pkg::ALPHA_NT: begin
                if (c == ckx_pkg::CH_A) code = 0;
                else if (c == ckx_pkg::CH_C) code = 1;
                else if (c == ckx_pkg::CH_G) code = 2;
                else if (c == ckx_pkg::CH_T) code = 3;
            end
            ckx_pkg::ALPHA_RY: begin
                if (c == ckx_pkg::CH_R) code = 0;
                else if (c == ckx_pkg::CH_Y) code = 1;
            end
            ckx_pkg::ALPHA_AA: begin
                for (int i = 0; i < 20; i++)
                    if (AMINO_ORDER[8*(19-i) +: 8] == c) code = i;
            end
            default: code = -1;
        endcase
        return code;
    endfunction

    // Advance the window by one text byte and queue the packed feature, if any
    task automatic extract_features(input logic [7:0] raw);
        logic [7:0]       c;
        int               code;
        int               k;
        int               bits;
        int               start;
        int               nbytes;
        int               p;
        logic [SYM_W-1:0] mask;
        logic [SYM_W-1:0] fwd [MAX_K];
        logic [SYM_W-1:0] rev [MAX_K];
        logic             use_rev;
        logic             decided;
        t_feat_byte       fb;

        c = raw;
        if (c == ckx_pkg::CH_GT) begin
            header_open = 1'b1;
            window_len  = 0;
            return;
        end
        if (header_open) begin
            if (c == ckx_pkg::CH_NL) header_open = 1'b0;
            return;
        end
        if (c == ckx_pkg::CH_NL) return;

        if (fold_en && c >= ckx_pkg::CH_LA && c <= ckx_pkg::CH_LZ) c = c - ckx_pkg::CASE_OFS;
        if (map_en) begin
            if (c == ckx_pkg::CH_A || c == ckx_pkg::CH_G) c = ckx_pkg::CH_R;
            else if (c == ckx_pkg::CH_C || c == ckx_pkg::CH_T) c = ckx_pkg::CH_Y;
        end
        code = symbol_code(c, alpha_mode);
        if (code < 0) begin
            window_len = 0;
            return;
        end

        if (window_len >= MAX_K) begin
            for (int i = 0; i < MAX_K - 1; i++) window_syms[i] = window_syms[i+1];
            window_len = MAX_K - 1;
        end
        window_syms[window_len] = code[SYM_W-1:0];
        window_len++;

        k = (kmer_len == 0) ? 1 : (kmer_len > MAX_K) ? MAX_K : int'(kmer_len);
        if (window_len < k) return;

        bits  = (alpha_mode == ckx_pkg::ALPHA_NT) ? 2 :
                (alpha_mode == ckx_pkg::ALPHA_RY) ? 1 : 5;
        mask  = SYM_W'((1 << bits) - 1);
        start = window_len - k;
        for (int i = 0; i < k; i++) fwd[i] = window_syms[start+i] & mask;

        // canonical strand: the lexicographically smaller of forward and revcomp
        use_rev = 1'b0;
        decided = 1'b0;
        if (rc_en && alpha_mode <= ckx_pkg::ALPHA_RY) begin
            for (int i = 0; i < k; i++) rev[i] = mask - fwd[k-1-i];
            for (int i = 0; i < k; i++) begin
                if (!decided && fwd[i] != rev[i]) begin
                    use_rev = (fwd[i] > rev[i]);
                    decided = 1'b1;
                end
            end
            if (use_rev)
                for (int i = 0; i < k; i++) fwd[i] = rev[i];
        end

        // MSB-first bit stream, zero-padded to whole 7-bit groups
        nbytes = (bits * k + GRP_W - 1) / GRP_W;
        for (int n = 0; n < nbytes; n++) begin
            fb.packed_byte = 8'h80;
            for (int j = 0; j < GRP_W; j++) begin
                p = GRP_W * n + j;
                if (p / bits < k) fb.packed_byte[GRP_W-1-j] = fwd[p/bits][bits-1-p%bits];
            end
            fb.last_byte = (n == nbytes - 1);
            owed_bytes = {owed_bytes, fb};
        end

        // keep the newest k-1 symbols
        for (int i = 0; i < k - 1; i++) window_syms[i] = window_syms[start+1+i];
        window_len = k - 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_len  = 0;
            header_open = 1'b0;
            kmer_len    = ckx_pkg::RST_KMER_LENGTH;
            alpha_mode  = ckx_pkg::ALPHA_NT;
            rc_en       = 1'b1;
            fold_en     = 1'b0;
            map_en      = 1'b0;
            foreach (window_syms[i]) window_syms[i] = '0;
            owed_bytes.delete();
        end else begin
            if (i_feat.valid && i_feat.ready) begin
                if (owed_bytes.size() == 0) begin
                    $display("%0t: output byte %02h (last %0b) with nothing owed",
                             $time, i_feat.packed_byte, i_feat.last_byte);
                    mismatches++;
                end else begin
                    want = owed_bytes.pop_front();
                    if (want.last_byte) features_seen++;
                    if (want.packed_byte !== i_feat.packed_byte) begin
                        $display("%0t: packed_byte expected %02h, actual %02h",
                                 $time, want.packed_byte, i_feat.packed_byte);
                        mismatches++;
                    end
                    if (want.last_byte !== i_feat.last_byte) begin
                        $display("%0t: last_byte expected %0b, actual %0b",
                                 $time, want.last_byte, i_feat.last_byte);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    ckx_pkg::REG_KMER_LENGTH: kmer_len   = i_cfg.data;
                    ckx_pkg::REG_ALPHA_MODE:  alpha_mode = i_cfg.data[1:0];
                    ckx_pkg::REG_REVCOMP_EN:  rc_en      = i_cfg.data[0];
                    ckx_pkg::REG_FOLD_LOWER:  fold_en    = i_cfg.data[0];
                    ckx_pkg::REG_PURPYR_MAP:  map_en     = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_text.valid && i_text.ready) extract_features(i_text.text_byte);
        end
        o_fail_count    <= mismatches;
        o_bytes_owed    <= owed_bytes.size();
        o_feature_count <= features_seen;
    end

endmodule

// ===== tb/tb_canonical_kmer_extractor_top.sv =====
// ============================================================================
// tb_canonical_kmer_extractor_top: testbench for the canonical k-mer extractor
// Drives FASTA text and register writes with random idle bursts, a long
// output hold-off and a full drain, across k from 0 to 63 and every alphabet
// mode. A separate checker predicts each packed feature byte and counts
// failures; this module only makes stimulus and gives the verdict.
// ============================================================================
module tb_canonical_kmer_extractor_top;

    localparam int MAX_K         = 32;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 12;    // settle time after the last owed byte
    localparam int HOLD_CYCLES   = 250;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer
    localparam int N_OPENING     = 21;

    // Extra codes the package leaves unnamed
    localparam logic [ckx_pkg::CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
    localparam logic [1:0]                    ALPHA_UNUSED = 2'd3;
    localparam logic [7:0]                    CH_UPPER_Z   = 8'h5A;

    // Opening text under reset settings (k=10, ACGT, revcomp on)
    localparam logic [7:0] OPENING_TEXT [N_OPENING] = '{
        // header, high byte, second '>'
        ckx_pkg::CH_GT, 8'hFF, ckx_pkg::CH_A, ckx_pkg::CH_GT, CH_UPPER_Z, ckx_pkg::CH_NL,
        // newline inside the sequence
        ckx_pkg::CH_A, ckx_pkg::CH_C, ckx_pkg::CH_G, ckx_pkg::CH_T, ckx_pkg::CH_NL,
        // tenth base emits
        ckx_pkg::CH_A, ckx_pkg::CH_C, ckx_pkg::CH_G, ckx_pkg::CH_T, ckx_pkg::CH_A,
        ckx_pkg::CH_C,
        ckx_pkg::CH_G,                                      // window slides by one
        ckx_pkg::CH_LA,                                     // unfolded lowercase clears
        8'h00, 8'h80                                        // extremes of the byte
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ckx_in_if  text_ch ();
    ckx_out_if feat_ch ();
    ckx_cfg_if cfg_ch ();

    int   fail_count;
    int   bytes_owed;
    int   feature_count;
    int   bytes_sent = 0;
    int   loads_done = 0;
    int   quiet_cycles = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;

    // Settings last loaded, used to shape the random text
    logic [1:0] cur_mode = ckx_pkg::ALPHA_NT;
    logic       cur_fold = 1'b0;
    logic       cur_map  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    canonical_kmer_extractor_top #(
        .MAX_K (MAX_K)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_feat  (feat_ch),
        .i_cfg   (cfg_ch)
    );

    ckx_feature_checker #(
        .MAX_K (MAX_K)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_text          (text_ch),
        .i_feat          (feat_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_bytes_owed    (bytes_owed),
        .o_feature_count (feature_count)
    );

    // Receiver: random stall bursts, or one long hold-off on request so that
    // the feature slots fill and the text input backs up.
    initial begin
        feat_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                feat_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                feat_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                feat_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                feat_ch.ready <= 1'b1;
            end else begin
                feat_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (text_ch.valid && text_ch.ready) || (feat_ch.valid && feat_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d bytes still owed",
                     $time, IDLE_LIMIT, bytes_owed);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one text byte, with an optional idle burst first; hold valid
    // after the transfer so back-to-back bytes need no second assignment.
    task automatic send_text(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop valid, wait until every owed byte has come, then let the pipeline settle
    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write every register on an idle block; unused upper data bits get noise
    task automatic load_settings(input logic [5:0] k, input logic [1:0] mode,
                                 input logic rc, input logic fold, input logic ry_map);
        logic [ckx_pkg::CFG_IDX_W-1:0]  idx [6];
        logic [ckx_pkg::CFG_DATA_W-1:0] val [6];
        idx = '{ckx_pkg::REG_KMER_LENGTH, ckx_pkg::REG_ALPHA_MODE, ckx_pkg::REG_REVCOMP_EN,
                ckx_pkg::REG_FOLD_LOWER, ckx_pkg::REG_PURPYR_MAP, REG_SPARE};
        val = '{k, {4'($urandom), mode}, {5'($urandom), rc},
                {5'($urandom), fold}, {5'($urandom), ry_map}, 6'($urandom)};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_mode = mode;
        cur_fold = fold;
        cur_map  = ry_map;
        loads_done++;
    endtask

    // A letter drawn for the current settings; a symbol except in the unused mode or with the RY map in ACGT mode
    function automatic logic [7:0] random_symbol();
        logic [8*20-1:0] amino  = "ACDEFGHIKLMNPQRSTVWY";
        logic [8*6-1:0]  ry_src = "RYACGT";
        logic [8*4-1:0]  bases  = "ACGT";
        logic [7:0]      c;
        case (cur_mode)
            ckx_pkg::ALPHA_AA: c = amino[8*$urandom_range(0, 19) +: 8];
            ckx_pkg::ALPHA_RY: c = cur_map ? ry_src[8*$urandom_range(0, 5) +: 8]
                                           : ry_src[8*$urandom_range(4, 5) +: 8];
            default:           c = bases[8*$urandom_range(0, 3) +: 8];
        endcase
        if (cur_fold && $urandom_range(0, 1) == 1) c = c + ckx_pkg::CASE_OFS;
        return c;
    endfunction

    // Mostly well-formed sequence lines; noise_pct of the draws are headers
    // or arbitrary bytes that break the window.
    task automatic send_random(input int count, input int noise_pct);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct / 3) begin
                send_text(ckx_pkg::CH_GT);
                repeat ($urandom_range(0, 4)) send_text(8'($urandom));
                send_text(ckx_pkg::CH_NL);
            end else if (r < noise_pct) begin
                send_text(8'($urandom));
            end else if (r < noise_pct + 8) begin
                send_text(ckx_pkg::CH_NL);
            end else begin
                send_text(random_symbol());
            end
        end
    endtask

    initial begin
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on reset settings
        for (int i = 0; i < N_OPENING; i++) send_text(OPENING_TEXT[i]);

        // Single-symbol features with folding
        load_settings(6'd1, ckx_pkg::ALPHA_NT, 1'b1, 1'b1, 1'b0);
        send_random(15, 12);
        // Longest nucleotide window, little noise so it fills
        load_settings(6'd32, ckx_pkg::ALPHA_NT, 1'b1, 1'b0, 1'b0);
        send_random(50, 1);
        // Lower k on a full window, forward strand only
        load_settings(6'd5, ckx_pkg::ALPHA_NT, 1'b0, 1'b1, 1'b0);
        send_random(18, 12);
        // Switch to RY over stored nucleotide codes, lowercase folded then mapped
        load_settings(6'd17, ckx_pkg::ALPHA_RY, 1'b0, 1'b1, 1'b1);
        send_random(18, 6);
        // Amino acids: k saturates at MAX_K, revcomp flag must be ignored
        load_settings(6'd63, ckx_pkg::ALPHA_AA, 1'b1, 1'b1, 1'b0);
        send_random(40, 1);
        // Shorter amino window with the RY map turning bases into R and Y
        load_settings(6'd7, ckx_pkg::ALPHA_AA, 1'b0, 1'b0, 1'b1);
        send_random(15, 12);
        // k of zero acts as one, canonical RY
        load_settings(6'd0, ckx_pkg::ALPHA_RY, 1'b1, 1'b0, 1'b0);
        send_random(15, 12);
        // Unused alphabet mode: every sequence byte clears
        load_settings(6'd12, ALPHA_UNUSED, 1'b1, 1'b0, 1'b0);
        send_random(10, 12);
        // RY map in nucleotide mode: mapped letters clear the window
        load_settings(6'd9, ckx_pkg::ALPHA_NT, 1'b1, 1'b0, 1'b1);
        send_random(10, 12);

        // Back-pressure: hold the output while clean bases keep coming so the
        // feature slots fill and the input stalls, then pause the sender
        // until the block has drained completely
        load_settings(6'd10, ckx_pkg::ALPHA_NT, 1'b1, 1'b0, 1'b0);
        hold_req = 1'b1;
        send_random(25, 0);
        wait_idle();
        send_random(10, 12);

        // Closing stretch at full rate on both sides; k above MAX_K saturates
        idle_on = 1'b0;
        load_settings(6'd40, ckx_pkg::ALPHA_NT, 1'b1, 1'b1, 1'b0);
        send_random(15, 1);

        wait_idle();
        $display("Sent %0d text bytes under %0d register loads; checked %0d packed features.",
                 bytes_sent, loads_done, feature_count);
        $display("Covered k 0..63, all four alphabet modes, folding, RY map and back-pressure.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ckx_pkg.sv
design/ckx_if.sv
design/ckx_decode.sv
design/ckx_cell.sv
design/ckx_align.sv
design/ckx_serializer.sv
design/canonical_kmer_extractor_top.sv
tb/ckx_feature_checker.sv
tb/tb_canonical_kmer_extractor_top.sv
